[design/l2log_pkg.sv]
// Package for the linear to 10-bit log pixel packer: widths, register map and defaults.
// Also holds the elaboration-time functions that build the log threshold ROM image.
// No dependencies.
package l2log_pkg;

    localparam int CODE_BITS_DEF   = 10;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_DEPTH       = 1024;

    localparam int VALUE_W    = 21;
    localparam int IN_DATA_W  = 64;
    localparam int WORD_W     = 32;
    localparam int CNT_W      = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic       REG_CHAN_LIMIT   = 1'b0;
    localparam logic [1:0] CHAN_LIMIT_RESET = 2'd3;

    localparam int REF_WHITE  = 685;
    localparam int REF_BLACK  = 95;
    localparam int HALF_STEPS = 600;
    localparam int BLACK_IDX  = 2 * REF_BLACK;
    localparam int WHITE_IDX  = 2 * REF_WHITE;

    localparam logic [63:0] Q52_ONE       = 64'h0010_0000_0000_0000;
    localparam logic [63:0] Q52_TEN       = Q52_ONE * 64'd10;
    localparam logic [63:0] Q52_HUNDREDTH = Q52_ONE / 64'd100;

    typedef logic [MAX_DEPTH-1:0][VALUE_W-1:0] rom_image_t;

    function automatic logic [63:0] q52_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[115:52];
    endfunction

    // Largest ratio whose 600th power, built by truncating multiplies, stays at or below ten.
    function automatic logic [63:0] step_ratio();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        int          k;
        lo = Q52_ONE;
        hi = Q52_ONE + Q52_HUNDREDTH;
        while ((hi - lo) > 64'd1)
        begin
            mid = lo + ((hi - lo) >> 1);
            p = Q52_ONE;
            k = 0;
            while ((k < HALF_STEPS) && (p <= Q52_TEN))
            begin
                p = q52_mul(p, mid);
                k = k + 1;
            end
            if (p <= Q52_TEN)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // Restoring division giving floor or ceiling of 65536 * num / den.
    function automatic logic [19:0] scaled_quotient(input logic [63:0] num,
                                                    input logic [63:0] den,
                                                    input logic        round_up);
        logic [79:0] n;
        logic [64:0] rem;
        logic [19:0] q;
        int          b;
        n   = {num, 16'd0};
        rem = '0;
        q   = '0;
        for (b = 79; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            q   = {q[18:0], 1'b0};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        if (round_up && (rem != '0))
            q = q + 20'd1;
        return q;
    endfunction

    function automatic rom_image_t build_table();
        rom_image_t  tbl;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] p_black;
        logic [63:0] p_white;
        logic [63:0] den;
        logic [19:0] q;
        int          k;
        tbl     = '0;
        r       = step_ratio();
        p       = Q52_ONE;
        p_black = '0;
        p_white = '0;
        for (k = 0; k <= WHITE_IDX; k++)
        begin
            if (k == BLACK_IDX)
                p_black = p;
            if (k == WHITE_IDX)
                p_white = p;
            p = q52_mul(p, r);
        end
        den = p_white - p_black;
        p = Q52_ONE;
        for (k = 0; k < 2 * MAX_DEPTH; k++)
        begin
            if (k[0])
            begin
                if (p >= p_black)
                begin
                    q = scaled_quotient(p - p_black, den, 1'b0);
                    tbl[k >> 1] = VALUE_W'(q);
                end
                else
                begin
                    q = scaled_quotient(p_black - p, den, 1'b1);
                    tbl[k >> 1] = VALUE_W'(0) - VALUE_W'(q);
                end
            end
            p = q52_mul(p, r);
        end
        return tbl;
    endfunction

endpackage

[design/linear_to_log10bit_pixel_pack.sv]
// Linear to log pixel packer: per-channel binary search over a threshold ROM, codes packed in a word.
// Depends on l2log_pkg for widths, register map and the ROM image builder.
// Channel          | Handshake                 | Payload
// s (pixel in)     | s_tvalid / s_tready       | s_tdata: red, green, blue (21 b each); s_tuser: window
// m (word out)     | m_tvalid / m_tready       | m_tdata: packed log codes (32 b)
// APB (config)     | psel, penable, pready     | encoded channel limit at byte address 0
// Channels are searched one after another, each with STEPS probes, STEPS = log2 of the search range;
// the single ROM read port sets the pace.
// Each ROM probe is read into a register (rom_q_reg) whose value feeds the next probe address.
// Reset clears all control state; the ROM needs no loading or clearing.
// A new pixel is taken while the previous word waits in the output register.
module linear_to_log10bit_pixel_pack #(
    parameter int CODE_BITS   = l2log_pkg::CODE_BITS_DEF,
    parameter int TABLE_DEPTH = l2log_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Bits from low: red_value [20:0], green_value [41:21], blue_value [62:42], zero [63].
    input  logic [l2log_pkg::IN_DATA_W-1:0]   s_tdata,
    // Bits from low: in_data_window [0].
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Bits from low: packed_word [31:0].
    output logic [l2log_pkg::WORD_W-1:0]      m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [l2log_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [l2log_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [l2log_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import l2log_pkg::*;

    localparam int LIMIT  = (TABLE_DEPTH < (1 << CODE_BITS)) ? TABLE_DEPTH : (1 << CODE_BITS);
    localparam int STEPS  = $clog2(LIMIT);
    localparam int BIT_W  = $clog2(STEPS);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [STEPS-1:0] LAST    = STEPS'(LIMIT - 1);
    localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(STEPS - 1);
    localparam int SH0 = WORD_W - CODE_BITS;
    localparam int SH1 = WORD_W - 2 * CODE_BITS;
    localparam int SH2 = WORD_W - 3 * CODE_BITS;
    localparam logic [WORD_W-1:0] LOW_MASK = WORD_W'((64'd1 << SH2) - 64'd1);
    localparam logic [1:0] CH_DONE = 2'd3;

    localparam rom_image_t ROM_IMAGE = build_table();

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg;
    logic [1:0]                 chan_reg, chan_next;
    logic [BIT_W-1:0]           bit_reg, bit_next;
    logic [STEPS-1:0]           pos_reg, pos_next;
    logic [WORD_W-1:0]          word_reg, word_next;
    logic                       win_reg;
    logic signed [VALUE_W-1:0]  red_reg, green_reg, blue_reg;
    logic signed [VALUE_W-1:0]  rom_q_reg;
    logic                       m_tvalid_reg;
    logic [WORD_W-1:0]          m_tdata_reg;

    logic                       in_fire;
    logic                       out_free;
    logic                       out_load;
    logic                       cfg_write;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [VALUE_W-1:0]  cur_val;
    logic [STEPS-1:0]           cand;
    logic                       hit;
    logic [STEPS-1:0]           pos_step;
    logic [STEPS-1:0]           next_cand;
    logic [STEPS-1:0]           first_cand;
    logic [WORD_W-1:0]          placed;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == ST_OUT) && out_free;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1:2] == REG_CHAN_LIMIT);
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_CHAN_LIMIT)
                       ? APB_DATA_W'(count_reg) : '0;

    always_comb
    begin
        case (chan_reg)
            2'd0:    cur_val = red_reg;
            2'd1:    cur_val = green_reg;
            default: cur_val = blue_reg;
        endcase
    end

    assign cand       = pos_reg | (STEPS'(1) << bit_reg);
    assign hit        = (cand <= LAST) && (rom_q_reg < cur_val);
    assign pos_step   = hit ? cand : pos_reg;
    assign next_cand  = pos_step | (STEPS'(1) << (bit_reg - BIT_W'(1)));
    assign first_cand = STEPS'(1) << TOP_BIT;

    always_comb
    begin
        case (chan_reg)
            2'd0:    placed = WORD_W'(pos_step) << SH0;
            2'd1:    placed = WORD_W'(pos_step) << SH1;
            default: placed = WORD_W'(pos_step) << SH2;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        bit_next   = bit_reg;
        pos_next   = pos_reg;
        word_next  = word_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    chan_next  = '0;
                    word_next  = '0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if ((chan_reg == CH_DONE) || !win_reg || (chan_reg >= count_reg))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    pos_next   = '0;
                    bit_next   = TOP_BIT;
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(first_cand - STEPS'(1));
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                pos_next = pos_step;
                if (bit_reg == '0)
                begin
                    word_next  = word_reg | placed;
                    chan_next  = chan_reg + 2'd1;
                    state_next = ST_START;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                    rd_en    = 1'b1;
                    if (next_cand <= LAST)
                        rd_addr = ADDR_W'(next_cand - STEPS'(1));
                end
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= CHAN_LIMIT_RESET;
            chan_reg     <= '0;
            bit_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            bit_reg   <= bit_next;
            if (cfg_write)
                count_reg <= pwdata[CNT_W-1:0];
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        word_reg <= word_next;
        if (in_fire)
        begin
            red_reg   <= s_tdata[VALUE_W-1:0];
            green_reg <= s_tdata[2*VALUE_W-1:VALUE_W];
            blue_reg  <= s_tdata[3*VALUE_W-1:2*VALUE_W];
            win_reg   <= s_tuser;
        end
        if (out_load)
            m_tdata_reg <= word_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rom_q_reg <= ROM_IMAGE[rd_addr];
    end

`ifndef SYNTHESIS
    a_out_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output became valid without a finished word");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (pos_reg <= LAST))
        else $error("search position beyond the code range");

    a_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !win_reg) |-> (word_reg == '0))
        else $error("pixel outside the window produced a nonzero word");

    a_low_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> ((m_tdata_reg & LOW_MASK) == '0))
        else $error("unused low bits of the output word are set");

    a_start_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_START && chan_reg == 2'd0 && word_reg == '0))
        else $error("engine did not start cleanly after an accepted beat");
`endif

endmodule

[verif/tb_linear_to_log10bit_pixel_pack.sv]
// Testbench for linear_to_log10bit_pixel_pack: streams pixels through the block under random
// pacing and checks every packed log word against a predictor that builds its own threshold ROM.
// Depends on l2log_pkg for port widths and the register map.
module tb_linear_to_log10bit_pixel_pack;

    localparam int CODE_W         = 10;
    localparam int TABLE_N        = 1024;
    localparam int BLACK_STEP     = 2 * 95;
    localparam int WHITE_STEP     = 2 * 685;
    localparam int POWER_STEPS    = 600;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLDOFF_AT     = 400;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int TIMEOUT_CYCLES = 800000;
    localparam int PHASES         = 7;

    localparam logic [63:0] FX_ONE = 64'd1 << 52;
    localparam logic [l2log_pkg::APB_ADDR_W-1:0] CHAN_LIMIT_ADDR =
        l2log_pkg::APB_ADDR_W'(4 * l2log_pkg::REG_CHAN_LIMIT);
    localparam logic signed [20:0] LINEAR_MIN = 21'sh10_0000;
    localparam logic signed [20:0] LINEAR_MAX = 21'sh0F_FFFF;

    typedef struct packed {
        logic signed [20:0] red;
        logic signed [20:0] green;
        logic signed [20:0] blue;
        logic               window;
    } pixel_t;

    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [l2log_pkg::IN_DATA_W-1:0]   s_tdata  = '0;
    logic                              s_tuser  = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [l2log_pkg::WORD_W-1:0]      m_tdata;
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [l2log_pkg::APB_ADDR_W-1:0]  paddr    = '0;
    logic [l2log_pkg::APB_DATA_W-1:0]  pwdata   = '0;
    logic [l2log_pkg::APB_DATA_W-1:0]  prdata;
    logic                              pready;

    logic signed [20:0] log_threshold [TABLE_N];
    logic [1:0]         chan_limit_cfg = 2'd3;

    pixel_t      pixel_q [$];
    logic [31:0] log_word_q [$];
    pixel_t      offered;
    logic [31:0] want_word;

    int burst_left    = 0;
    int gap_left      = 0;
    int segment_left  = 0;
    int ready_pct     = 100;
    int holdoff_left  = 0;
    bit holdoff_done  = 1'b0;
    int words_seen    = 0;
    int error_count   = 0;

    int phase_count [PHASES] = '{1, 0, 2, 3, 2, 1, 3};
    int phase_items [PHASES] = '{150, 100, 200, 300, 100, 80, 70};

    linear_to_log10bit_pixel_pack u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        wide = wide >> 52;
        return wide[63:0];
    endfunction

    // Largest ratio whose power over one decade of half steps stays at or below ten.
    function automatic logic [63:0] decade_ratio();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] acc;
        int          n;
        lo = FX_ONE;
        hi = FX_ONE + FX_ONE / 64'd100;
        while ((hi - lo) > 64'd1)
        begin
            mid = lo + (hi - lo) / 64'd2;
            acc = FX_ONE;
            for (n = 0; n < POWER_STEPS; n++)
                acc = fx_mul(acc, mid);
            if (acc <= FX_ONE * 64'd10)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    task automatic build_log_thresholds();
        logic [63:0] ratio;
        logic [63:0] p;
        logic [63:0] p_black;
        logic [63:0] p_white;
        logic [63:0] span;
        logic [79:0] num;
        logic [79:0] quo;
        int          k;
        ratio   = decade_ratio();
        p       = FX_ONE;
        p_black = '0;
        p_white = '0;
        for (k = 0; k <= WHITE_STEP; k++)
        begin
            if (k == BLACK_STEP)
                p_black = p;
            if (k == WHITE_STEP)
                p_white = p;
            p = fx_mul(p, ratio);
        end
        span = p_white - p_black;
        p = FX_ONE;
        for (k = 0; k < 2 * TABLE_N; k++)
        begin
            if ((k % 2) == 1)
            begin
                if (p >= p_black)
                begin
                    num = {p - p_black, 16'd0};
                    quo = num / span;
                    log_threshold[k / 2] = quo[20:0];
                end
                else
                begin
                    // Below the black point the quotient rounds away from zero.
                    num = {p_black - p, 16'd0};
                    quo = num / span;
                    if ((num % span) != 80'd0)
                        quo = quo + 80'd1;
                    log_threshold[k / 2] = 21'd0 - quo[20:0];
                end
            end
            p = fx_mul(p, ratio);
        end
    endtask

    // Counts thresholds strictly below the value, saturating at the top code.
    function automatic logic [CODE_W-1:0] log_code(input logic signed [20:0] v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = TABLE_N;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (log_threshold[mid] < v)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo > (1 << CODE_W) - 1)
            lo = (1 << CODE_W) - 1;
        return lo[CODE_W-1:0];
    endfunction

    function automatic logic [31:0] predict_word(input pixel_t px, input logic [1:0] count);
        logic [31:0]        word;
        logic signed [20:0] chan [3];
        int                 c;
        word    = '0;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        if (px.window)
        begin
            for (c = 0; c < 3 && c < int'(count); c++)
                word = word | (32'(log_code(chan[c])) << (32 - CODE_W * (c + 1)));
        end
        return word;
    endfunction

    function automatic logic signed [20:0] random_linear();
        logic signed [20:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = 21'($urandom);
            4, 5, 6:
                v = log_threshold[$urandom_range(TABLE_N - 1)] + 21'($urandom_range(2)) - 21'd1;
            7:
            begin
                case ($urandom_range(2))
                    0: v = LINEAR_MIN;
                    1: v = LINEAR_MAX;
                    default: v = '0;
                endcase
            end
            default: v = 21'($urandom_range(900000));
        endcase
        return v;
    endfunction

    task automatic queue_pixel(input logic signed [20:0] r, input logic signed [20:0] g,
                               input logic signed [20:0] b, input logic w);
        pixel_t px;
        px.red    = r;
        px.green  = g;
        px.blue   = b;
        px.window = w;
        pixel_q.insert(pixel_q.size(), px);
    endtask

    task automatic queue_random_pixels(input int n);
        int i;
        for (i = 0; i < n; i++)
            queue_pixel(random_linear(), random_linear(), random_linear(),
                        $urandom_range(7) != 0);
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_tvalid || log_word_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_chan_limit(input logic [1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CHAN_LIMIT_ADDR;
        pwdata  <= l2log_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        chan_limit_cfg = value;
    endtask

    // The sender offers pixels in bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                log_word_q.insert(log_word_q.size(), predict_word(offered, chan_limit_cfg));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_q.size() != 0)
                begin
                    offered = pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, offered.blue, offered.green, offered.red};
                    s_tuser  <= offered.window;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 25);
                    end
                    else
                    begin
                        burst_left = burst_left - 1;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // The receiver changes its readiness pattern per segment and holds off once for a long time.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left = holdoff_left - 1;
            m_tready <= 1'b0;
        end
        else if (words_seen >= HOLDOFF_AT && !holdoff_done)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            if (segment_left == 0)
            begin
                segment_left = $urandom_range(16, 160);
                case ($urandom_range(3))
                    0: ready_pct = 100;
                    1: ready_pct = 70;
                    2: ready_pct = 30;
                    default: ready_pct = 8;
                endcase
            end
            else
            begin
                segment_left = segment_left - 1;
            end
            m_tready <= ($urandom_range(99) < ready_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            words_seen <= words_seen + 1;
            if (log_word_q.size() == 0)
            begin
                error_count = error_count + 1;
                if (error_count <= 10)
                    $display("Unexpected output beat: packed_word %h", m_tdata);
            end
            else
            begin
                want_word = log_word_q.pop_front();
                if (m_tdata !== want_word)
                begin
                    error_count = error_count + 1;
                    if (error_count <= 10)
                        $display("Mismatch on packed_word: expected %h, actual %h",
                                 want_word, m_tdata);
                end
            end
        end
    end

    initial
    begin
        int p;
        build_log_thresholds();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        queue_pixel(LINEAR_MAX, LINEAR_MAX, LINEAR_MAX, 1'b1);
        queue_pixel(LINEAR_MIN, LINEAR_MIN, LINEAR_MIN, 1'b1);
        queue_pixel('0, '0, '0, 1'b1);
        queue_pixel(LINEAR_MAX, LINEAR_MAX, LINEAR_MAX, 1'b0);
        queue_pixel(21'sd65536, 21'sd12345, -21'sd7, 1'b0);
        queue_pixel(log_threshold[0], log_threshold[0] + 21'sd1, log_threshold[0] - 21'sd1,
                    1'b1);
        queue_pixel(log_threshold[TABLE_N - 1], log_threshold[TABLE_N - 1] + 21'sd1,
                    log_threshold[TABLE_N - 2] + 21'sd1, 1'b1);
        queue_pixel(log_threshold[512], log_threshold[512] + 21'sd1, -21'sd1, 1'b1);
        queue_pixel(21'sd65536, 21'sd1, LINEAR_MIN + 21'sd1, 1'b1);
        queue_pixel(LINEAR_MAX - 21'sd1, 21'sh0A_AAAA, 21'sh15_5555, 1'b1);
        queue_pixel(21'sh15_5555, 21'sh0A_AAAA, log_threshold[1], 1'b1);
        queue_pixel(log_threshold[1023] - 21'sd1, log_threshold[300], log_threshold[700],
                    1'b1);
        queue_random_pixels(10);
        queue_random_pixels(75);
        wait_drained();
        queue_random_pixels(75);
        wait_drained();

        for (p = 0; p < PHASES; p++)
        begin
            write_chan_limit(2'(phase_count[p]));
            queue_random_pixels(phase_items[p]);
            wait_drained();
        end

        if (error_count == 0)
            $display("** linear_to_log10bit_pixel_pack: PASSED **");
        else
            $display("** linear_to_log10bit_pixel_pack: FAILED **");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 4);
        $display("** linear_to_log10bit_pixel_pack: FAILED **");
        $finish;
    end

endmodule
